### rtl/deadline_max_heap_cpu_picker_defines.svh
// Assertion macros used by the checker file.
`ifndef DEADLINE_MAX_HEAP_CPU_PICKER_DEFINES_SVH
`define DEADLINE_MAX_HEAP_CPU_PICKER_DEFINES_SVH

// Implication checked at every rising clock edge outside reset.
`define DMH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define DMH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/dmh_pkg.sv
`default_nettype none
package dmh_pkg;
	localparam int NumCpus = 16;
	localparam int CpuW = 4;
	localparam int SlotW = 5;
	localparam int DlW = 64;

	typedef enum logic [1:0] {
		MODE_SET = 2'd0,
		MODE_CLEAR = 2'd1,
		MODE_FIND = 2'd2,
		MODE_NONE = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SET_RD,
		ST_CLR_RD,
		ST_CLR_MOVE,
		ST_UP_RD,
		ST_UP_CMP,
		ST_DN_RD_L,
		ST_DN_RD_R,
		ST_DN_CMP,
		ST_SWAP_A,
		ST_SWAP_B,
		ST_FIND,
		ST_OUT
	} state_t;

	// True when a lies before b in wrapping time.
	function automatic logic earlier(input logic [DlW-1:0] a, input logic [DlW-1:0] b);
		logic [DlW-1:0] d;
		d = a - b;
		return d[DlW-1];
	endfunction
endpackage
`default_nettype wire

### rtl/dmh_heap_mem.sv
`default_nettype none
module dmh_heap_mem
	import dmh_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [CpuW-1:0]      waddr,
	input  wire logic [DlW-1:0]       wdl,
	input  wire logic [CpuW-1:0]      wcpu,
	input  wire logic [CpuW-1:0]      raddr,
	output logic      [DlW-1:0]       rdl,
	output logic      [CpuW-1:0]      rcpu
);
	logic [DlW-1:0]  dl_mem [NumCpus];
	logic [CpuW-1:0] cpu_mem [NumCpus];

	always_ff @(posedge clk) begin
		if (we) begin
			dl_mem[waddr] <= wdl;
			cpu_mem[waddr] <= wcpu;
		end
		rdl <= dl_mem[raddr];
		rcpu <= cpu_mem[raddr];
	end
endmodule
`default_nettype wire

### rtl/deadline_max_heap_cpu_picker.sv
// Channel | direction | handshake           | payload
// cfg     | in        | cfg_valid/cfg_ready | cfg_data (active_cpus)
// in      | in        | in_valid/in_ready   | mode, cpu_id, deadline, allowed_mask
// out     | out       | out_valid/out_ready | found, pick_cpu, candidate_mask
// One item at a time: a find passes ST_FIND, then waits in ST_OUT for out_ready. A set or
// clear reads the heap, then sifts up (parent read, compare, swap A, B) or down (child reads,
// compare, swap A, B), at most four levels for sixteen CPUs, through the one heap read port.
// arst_n empties slot map and count and sets free and active masks at once; no clearing pass.
// A find result waits in the output register while out_ready is low; in_ready stays low.
`default_nettype none
module deadline_max_heap_cpu_picker
	import dmh_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [NumCpus-1:0] cfg_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        mode,
	input  wire logic [CpuW-1:0]   cpu_id,
	input  wire logic [DlW-1:0]    deadline,
	input  wire logic [NumCpus-1:0] allowed_mask,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   found,
	output logic [CpuW-1:0]        pick_cpu,
	output logic [NumCpus-1:0]     candidate_mask
);
	state_t state_q, state_d;
	logic [SlotW-1:0] slot_q [NumCpus];
	logic [SlotW-1:0] count_q;
	logic [NumCpus-1:0] free_q, active_q;
	logic [1:0] mode_q;
	logic [CpuW-1:0] cpu_q;
	logic [DlW-1:0] dl_q;
	logic [NumCpus-1:0] allow_q;
	// Sift position and the entry that moves with it.
	logic [CpuW-1:0] pos_q, other_q;
	logic [DlW-1:0] cur_dl_q, oth_dl_q, l_dl_q;
	logic [CpuW-1:0] cur_cpu_q, oth_cpu_q, l_cpu_q;
	logic down_q, has_r_q;

	logic mem_we;
	logic [CpuW-1:0] mem_waddr, mem_raddr, mem_wcpu, mem_rcpu;
	logic [DlW-1:0] mem_wdl, mem_rdl;

	dmh_heap_mem u_mem (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdl(mem_wdl), .wcpu(mem_wcpu),
		.raddr(mem_raddr), .rdl(mem_rdl), .rcpu(mem_rcpu)
	);

	logic [SlotW-1:0] slot_cur;
	logic [SlotW-1:0] lidx, ridx;
	logic [CpuW-1:0] parent;
	logic [NumCpus-1:0] cand;
	logic [CpuW-1:0] lowest;

	assign slot_cur = slot_q[cpu_q];
	assign parent = CpuW'((pos_q - 1'b1) >> 1);
	assign lidx = {pos_q, 1'b1};
	assign ridx = SlotW'({pos_q, 1'b0}) + SlotW'(2);
	assign cand = free_q & allow_q & active_q;

	always_comb begin
		lowest = '0;
		for (int i = NumCpus - 1; i >= 0; i--) begin
			if (cand[i]) lowest = CpuW'(i);
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);

	// The first compare of a change of key, before any sift step.
	logic rekey;
	assign rekey = (mode_q == MODE_SET) && !has_r_q;

	// Read address for the memory.
	always_comb begin
		unique case (state_q)
			ST_SET_RD: mem_raddr = slot_cur[CpuW-1:0];
			ST_CLR_RD: mem_raddr = CpuW'(count_q - 1'b1);
			ST_UP_RD: mem_raddr = parent;
			ST_DN_RD_L: mem_raddr = lidx[CpuW-1:0];
			ST_DN_RD_R: mem_raddr = ridx[CpuW-1:0];
			default: mem_raddr = '0;
		endcase
	end

	// Writes: swaps place both entries; up reads and rekeys write the current entry.
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = pos_q;
		mem_wdl = cur_dl_q;
		mem_wcpu = cur_cpu_q;
		unique case (state_q)
			ST_SWAP_A: begin
				mem_we = 1'b1;
				mem_waddr = pos_q;
				mem_wdl = oth_dl_q;
				mem_wcpu = oth_cpu_q;
			end
			ST_SWAP_B: begin
				mem_we = 1'b1;
				mem_waddr = other_q;
				mem_wdl = cur_dl_q;
				mem_wcpu = cur_cpu_q;
			end
			ST_UP_RD: begin
				mem_we = 1'b1;
			end
			ST_UP_CMP: begin
				mem_we = rekey;
			end
			default: ;
		endcase
	end

	logic up_swap, dn_l, dn_r;
	assign up_swap = (pos_q != '0) && earlier(mem_rdl, cur_dl_q);
	assign dn_l = (lidx < count_q) && earlier(cur_dl_q, l_dl_q);
	assign dn_r = has_r_q && (dn_l ? earlier(l_dl_q, mem_rdl) : earlier(cur_dl_q, mem_rdl));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (mode_t'(mode))
						MODE_SET: state_d = ST_SET_RD;
						MODE_CLEAR: state_d = ST_CLR_RD;
						MODE_FIND: state_d = ST_FIND;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_SET_RD: state_d = (slot_cur >= count_q) ?
				((count_q >= SlotW'(NumCpus)) ? ST_IDLE : ST_UP_RD) : ST_UP_CMP;
			ST_CLR_RD: state_d = (slot_cur >= count_q) ? ST_IDLE :
				((slot_cur == count_q - 1'b1) ? ST_IDLE : ST_CLR_MOVE);
			ST_CLR_MOVE: state_d = ST_UP_RD;
			ST_UP_RD: state_d = ST_UP_CMP;
			ST_UP_CMP: begin
				if (rekey) state_d = earlier(dl_q, mem_rdl) ? ST_DN_RD_L : ST_UP_RD;
				else state_d = up_swap ? ST_SWAP_A : (mode_q == MODE_CLEAR && !has_r_q
					? ST_DN_RD_L : ST_IDLE);
			end
			ST_DN_RD_L: state_d = (lidx < count_q) ? ST_DN_RD_R : ST_IDLE;
			ST_DN_RD_R: state_d = ST_DN_CMP;
			ST_DN_CMP: state_d = (dn_l || dn_r) ? ST_SWAP_A : ST_IDLE;
			ST_SWAP_A: state_d = ST_SWAP_B;
			ST_SWAP_B: state_d = down_q ? ST_DN_RD_L : ST_UP_RD;
			ST_FIND: state_d = ST_OUT;
			ST_OUT: state_d = out_ready ? ST_IDLE : ST_OUT;
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = (state_q == ST_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			free_q <= '1;
			active_q <= '1;
			for (int i = 0; i < NumCpus; i++) slot_q[i] <= SlotW'(NumCpus);
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) active_q <= cfg_data;
			unique case (state_q)
				ST_SET_RD: begin
					if (slot_cur >= count_q) begin
						if (count_q < SlotW'(NumCpus)) begin
							pos_q <= count_q[CpuW-1:0];
							slot_q[cpu_q] <= count_q;
							count_q <= count_q + 1'b1;
							free_q[cpu_q] <= 1'b0;
							down_q <= 1'b0;
							has_r_q <= 1'b1;
						end
					end else begin
						pos_q <= slot_cur[CpuW-1:0];
						down_q <= 1'b0;
						has_r_q <= 1'b0;
					end
				end
				ST_CLR_RD: begin
					if (slot_cur < count_q) begin
						slot_q[cpu_q] <= SlotW'(NumCpus);
						free_q[cpu_q] <= 1'b1;
						count_q <= count_q - 1'b1;
						pos_q <= slot_cur[CpuW-1:0];
					end
				end
				ST_CLR_MOVE: begin
					cur_dl_q <= mem_rdl;
					cur_cpu_q <= mem_rcpu;
					slot_q[mem_rcpu] <= {1'b0, pos_q};
					down_q <= 1'b0;
					has_r_q <= 1'b0;
				end
				ST_UP_CMP: begin
					// A change of key compares old and new before any sift.
					if (rekey) begin
						cur_dl_q <= dl_q;
						cur_cpu_q <= cpu_q;
						has_r_q <= 1'b1;
						down_q <= earlier(dl_q, mem_rdl);
					end else begin
						oth_dl_q <= mem_rdl;
						oth_cpu_q <= mem_rcpu;
						other_q <= parent;
						if (up_swap) has_r_q <= 1'b1;
					end
				end
				ST_DN_RD_L: begin
					down_q <= 1'b1;
				end
				ST_DN_RD_R: begin
					l_dl_q <= mem_rdl;
					l_cpu_q <= mem_rcpu;
					has_r_q <= (ridx < count_q);
				end
				ST_DN_CMP: begin
					if (dn_r) begin
						oth_dl_q <= mem_rdl;
						oth_cpu_q <= mem_rcpu;
						other_q <= ridx[CpuW-1:0];
					end else begin
						oth_dl_q <= l_dl_q;
						oth_cpu_q <= l_cpu_q;
						other_q <= lidx[CpuW-1:0];
					end
				end
				ST_SWAP_A: begin
					slot_q[oth_cpu_q] <= {1'b0, pos_q};
					slot_q[cur_cpu_q] <= {1'b0, other_q};
				end
				ST_SWAP_B: begin
					pos_q <= other_q;
				end
				ST_FIND: begin
					if (cand != '0) begin
						found <= 1'b1;
						pick_cpu <= lowest;
						candidate_mask <= cand;
					end else if (count_q != '0 && allow_q[mem_rcpu] && earlier(dl_q, mem_rdl)) begin
						found <= 1'b1;
						pick_cpu <= mem_rcpu;
						candidate_mask <= NumCpus'(1) << mem_rcpu;
					end else begin
						found <= 1'b0;
						pick_cpu <= '0;
						candidate_mask <= '0;
					end
				end
				default: ;
			endcase
			if (state_q == ST_IDLE && in_valid) begin
				mode_q <= mode;
				cpu_q <= cpu_id;
				dl_q <= deadline;
				allow_q <= allowed_mask;
				cur_dl_q <= deadline;
				cur_cpu_q <= cpu_id;
				has_r_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

### rtl/dmh_checker.sv
`default_nettype none
`include "deadline_max_heap_cpu_picker_defines.svh"
module dmh_checker
	import dmh_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic found,
	input wire logic [CpuW-1:0] pick_cpu,
	input wire logic [NumCpus-1:0] candidate_mask
);
	`DMH_ASSERT_IMP(a_busy_out, clk, arst_n, out_valid, !in_ready)
	`DMH_ASSERT_IMP(a_nf_zero, clk, arst_n, out_valid && !found, pick_cpu == '0 && candidate_mask == '0)
	`DMH_ASSERT_IMP(a_found_bit, clk, arst_n, out_valid && found, candidate_mask[pick_cpu])
	`DMH_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(pick_cpu))
endmodule

bind deadline_max_heap_cpu_picker dmh_checker u_dmh_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .found(found),
	.pick_cpu(pick_cpu), .candidate_mask(candidate_mask)
);
`default_nettype wire
